// File: hw/rtl/dvc_pkg.sv
// Shared types, constants and helper functions for the differential vector clock unit.
// No dependencies.
package dvc_pkg;

   localparam int MAX_NODES  = 16;
   localparam int CLOCK_BITS = 32;
   localparam int IDX_W      = $clog2(MAX_NODES);
   localparam int ACT_MAX    = (MAX_NODES < 16) ? MAX_NODES : 16;
   localparam int CNT_W      = $clog2(ACT_MAX + 1);

   typedef enum logic [1:0] {
      FUNC_INTERNAL   = 2'd0,
      FUNC_SEND       = 2'd1,
      FUNC_RECV_START = 2'd2,
      FUNC_RECV_PAIR  = 2'd3
   } func_type;

   typedef enum logic {
      CSR_NODE_ID      = 1'b0,
      CSR_ACTIVE_NODES = 1'b1
   } csr_index_type;

   typedef logic [CLOCK_BITS-1:0] clock_type;
   localparam clock_type CLOCK_MAX = '1;

   // one store entry: clock value, own clock at last update, own clock at last send
   typedef struct packed {
      clock_type clk;
      clock_type lut;
      clock_type lst;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      row_type          wr_row;
   } mem_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] own;
      logic [CNT_W-1:0] act;
   } cfg_type;

   function automatic clock_type sat_pair(input logic [31:0] v);
      if (64'(v) > 64'(CLOCK_MAX)) begin
         return CLOCK_MAX;
      end
      return CLOCK_BITS'(v);
   endfunction

   function automatic clock_type sat_inc(input clock_type c);
      if (c == CLOCK_MAX) begin
         return c;
      end
      return c + clock_type'(1);
   endfunction

endpackage

// File: hw/rtl/dvc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/dvc_store.sv
// Entry store: RAM of rows plus per-entry valid bits; an unwritten entry reads as zero.
// Depends on dvc_pkg and dvc_ram.
module dvc_store (
   input  logic                clock,
   input  logic                reset,
   input  dvc_pkg::mem_req_type mem_req,
   output dvc_pkg::row_type    rd_row
);

   logic [dvc_pkg::MAX_NODES-1:0] valid_ff, valid_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic [dvc_pkg::ROW_W-1:0]     ram_q;

   dvc_ram #(
      .WIDTH(dvc_pkg::ROW_W),
      .DEPTH(dvc_pkg::MAX_NODES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_req.wr_en),
      .wr_addr(mem_req.wr_addr),
      .wr_data(mem_req.wr_row),
      .rd_en  (mem_req.rd_en),
      .rd_addr(mem_req.rd_addr),
      .rd_data(ram_q)
   );

   always_comb begin
      valid_in    = valid_ff;
      rd_valid_in = rd_valid_ff;
      if (mem_req.wr_en) begin
         valid_in[mem_req.wr_addr] = 1'b1;
      end
      if (mem_req.rd_en) begin
         rd_valid_in = valid_ff[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign rd_row = rd_valid_ff ? dvc_pkg::row_type'(ram_q) : '0;

endmodule

// File: hw/rtl/dvc_engine.sv
// Sequencer: read-modify-write of store rows per transaction, send sweep and result register.
// Depends on dvc_pkg.
module dvc_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  dvc_pkg::cfg_type     cfg,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic [3:0]           req_peer,
   input  logic [3:0]           req_pair_index,
   input  logic [31:0]          req_pair_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [3:0]           rsp_out_index,
   output logic [31:0]          rsp_out_value,
   output logic                 rsp_last_pair,
   output dvc_pkg::mem_req_type mem_req,
   input  dvc_pkg::row_type     rd_row
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_TICK     = 8'b0000_0010,
      ST_PEER_RD  = 8'b0000_0100,
      ST_PEER     = 8'b0000_1000,
      ST_SWEEP    = 8'b0001_0000,
      ST_FLUSH    = 8'b0010_0000,
      ST_PAIR_OWN = 8'b0100_0000,
      ST_PAIR     = 8'b1000_0000
   } state_type;

   state_type                 state_ff, state_in;
   dvc_pkg::func_type         func_ff, func_in;
   logic [3:0]                peer_ff, peer_in;
   logic [3:0]                pidx_ff, pidx_in;
   dvc_pkg::clock_type        pval_ff, pval_in;
   dvc_pkg::clock_type        own_clk_ff, own_clk_in;
   dvc_pkg::clock_type        since_ff, since_in;
   dvc_pkg::row_type          peer_row_ff, peer_row_in;
   logic [dvc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic [3:0]                pend_idx_ff, pend_idx_in;
   dvc_pkg::clock_type        pend_val_ff, pend_val_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [3:0]                rsp_idx_ff, rsp_idx_in;
   logic [31:0]               rsp_val_ff, rsp_val_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      out_busy;
   logic                      push;
   logic                      push_last;
   logic                      qual;
   logic [dvc_pkg::CNT_W-1:0] cnt_next;
   dvc_pkg::clock_type        tick_val;

   assign out_busy = rsp_valid_ff && rsp_stall;
   assign qual     = since_ff < rd_row.lut;
   assign cnt_next = cnt_ff + dvc_pkg::CNT_W'(1);
   assign tick_val = dvc_pkg::sat_inc(rd_row.clk);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      peer_in       = peer_ff;
      pidx_in       = pidx_ff;
      pval_in       = pval_ff;
      own_clk_in    = own_clk_ff;
      since_in      = since_ff;
      peer_row_in   = peer_row_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_val_in   = pend_val_ff;
      push          = 1'b0;
      push_last     = 1'b0;
      mem_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in = dvc_pkg::func_type'(req_func);
               peer_in = req_peer;
               pidx_in = req_pair_index;
               pval_in = dvc_pkg::sat_pair(req_pair_value);
               if (dvc_pkg::func_type'(req_func) == dvc_pkg::FUNC_RECV_PAIR) begin
                  if (32'(req_pair_index) < 32'(cfg.act)) begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = cfg.own;
                     state_in        = ST_PAIR_OWN;
                  end
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = cfg.own;
                  state_in        = ST_TICK;
               end
            end
         end
         ST_TICK: begin
            mem_req.wr_en      = 1'b1;
            mem_req.wr_addr    = cfg.own;
            mem_req.wr_row.clk = tick_val;
            mem_req.wr_row.lut = tick_val;
            mem_req.wr_row.lst = rd_row.lst;
            own_clk_in         = tick_val;
            if (func_ff == dvc_pkg::FUNC_SEND && 32'(peer_ff) < 32'(cfg.act)) begin
               state_in = ST_PEER_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PEER_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = dvc_pkg::IDX_W'(peer_ff);
            state_in        = ST_PEER;
         end
         ST_PEER: begin
            since_in        = rd_row.lst;
            peer_row_in     = rd_row;
            pend_valid_in   = 1'b0;
            cnt_in          = '0;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = '0;
            state_in        = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (!(qual && pend_valid_ff && out_busy)) begin
               if (qual) begin
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_idx_in   = 4'(cnt_ff);
                  pend_val_in   = rd_row.clk;
               end
               if (cnt_next == cfg.act) begin
                  state_in = ST_FLUSH;
               end else begin
                  cnt_in          = cnt_next;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = dvc_pkg::IDX_W'(cnt_next);
               end
            end
         end
         ST_FLUSH: begin
            if (!(pend_valid_ff && out_busy)) begin
               push               = pend_valid_ff;
               push_last          = 1'b1;
               pend_valid_in      = 1'b0;
               mem_req.wr_en      = 1'b1;
               mem_req.wr_addr    = dvc_pkg::IDX_W'(peer_ff);
               mem_req.wr_row.clk = peer_row_ff.clk;
               mem_req.wr_row.lut = peer_row_ff.lut;
               mem_req.wr_row.lst = own_clk_ff;
               state_in           = ST_IDLE;
            end
         end
         ST_PAIR_OWN: begin
            own_clk_in      = rd_row.clk;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = dvc_pkg::IDX_W'(pidx_ff);
            state_in        = ST_PAIR;
         end
         ST_PAIR: begin
            if (pval_ff > rd_row.clk) begin
               mem_req.wr_en      = 1'b1;
               mem_req.wr_addr    = dvc_pkg::IDX_W'(pidx_ff);
               mem_req.wr_row.clk = pval_ff;
               mem_req.wr_row.lut = (dvc_pkg::IDX_W'(pidx_ff) == cfg.own) ? pval_ff
                                                                          : own_clk_ff;
               mem_req.wr_row.lst = rd_row.lst;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = pend_idx_ff;
         rsp_val_in   = 32'(pend_val_ff);
         rsp_last_in  = push_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_in_reg: begin
         func_ff     <= func_in;
         peer_ff     <= peer_in;
         pidx_ff     <= pidx_in;
         pval_ff     <= pval_in;
         own_clk_ff  <= own_clk_in;
         since_ff    <= since_in;
         peer_row_ff <= peer_row_in;
         cnt_ff      <= cnt_in;
         pend_idx_ff <= pend_idx_in;
         pend_val_ff <= pend_val_in;
         rsp_idx_ff  <= rsp_idx_in;
         rsp_val_ff  <= rsp_val_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_idx_ff;
   assign rsp_out_value = rsp_val_ff;
   assign rsp_last_pair = rsp_last_ff;

endmodule

// File: hw/rtl/differential_vector_clock_unit.sv
// Channel   Direction  Handshake         Payload
// req_      in         valid / stall     func, peer, pair_index, pair_value
// rsp_      out        valid / stall     out_index, out_value, last_pair
// csr_      in         valid / ready     index, data (node_id, active_nodes)
//
// Internal and receive-start transactions tick the own entry; an in-range receive pair
// raises the pair entry if larger; an out-of-range pair is dropped. A send to an active peer
// ticks and sweeps min(active_nodes, 16) rows, one to an inactive peer only ticks: the
// sweep reads one store row per cycle through the single RAM read port; a stalled result
// channel holds the sweep and the final flush. Synchronous reset clears control and the
// store valid bits at once, so no clearing pass is needed. csr_ready is always high.
// Top level: configuration registers, store and sequencer. Depends on dvc_pkg,
// dvc_store, dvc_engine.
module differential_vector_clock_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_peer,
   input  logic [3:0]  req_pair_index,
   input  logic [31:0] req_pair_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_out_index,
   output logic [31:0] rsp_out_value,
   output logic        rsp_last_pair,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [4:0]  csr_data
);

   logic [3:0]           node_id_ff, node_id_in;
   logic [4:0]           active_nodes_ff, active_nodes_in;
   dvc_pkg::cfg_type     cfg;
   dvc_pkg::mem_req_type mem_req;
   dvc_pkg::row_type     rd_row;

   assign csr_ready = 1'b1;

   always_comb begin
      node_id_in      = node_id_ff;
      active_nodes_in = active_nodes_ff;
      if (csr_valid && csr_ready) begin
         unique case (dvc_pkg::csr_index_type'(csr_index))
            dvc_pkg::CSR_NODE_ID:      node_id_in      = csr_data[3:0];
            dvc_pkg::CSR_ACTIVE_NODES: active_nodes_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff      <= '0;
         active_nodes_ff <= 5'd16;
      end else begin
         node_id_ff      <= node_id_in;
         active_nodes_ff <= active_nodes_in;
      end
   end

   assign cfg.own = (32'(node_id_ff) < dvc_pkg::MAX_NODES) ?
                    dvc_pkg::IDX_W'(node_id_ff) : dvc_pkg::IDX_W'(dvc_pkg::MAX_NODES - 1);
   assign cfg.act = (32'(active_nodes_ff) > dvc_pkg::ACT_MAX) ?
                    dvc_pkg::CNT_W'(dvc_pkg::ACT_MAX) : dvc_pkg::CNT_W'(active_nodes_ff);

   dvc_store u_store (
      .clock  (clock),
      .reset  (reset),
      .mem_req(mem_req),
      .rd_row (rd_row)
   );

   dvc_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_peer      (req_peer),
      .req_pair_index(req_pair_index),
      .req_pair_value(req_pair_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_index (rsp_out_index),
      .rsp_out_value (rsp_out_value),
      .rsp_last_pair (rsp_last_pair),
      .mem_req       (mem_req),
      .rd_row        (rd_row)
   );

endmodule

// File: hw/rtl/dvc_checker.sv
// Port-level checker for differential_vector_clock_unit, attached by bind.
// Depends on dvc_pkg.
module dvc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_func,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_out_index,
   input logic [31:0] rsp_out_value,
   input logic        rsp_last_pair
);

   logic tick_accept;

   assign tick_accept = req_valid && !req_stall &&
                        (req_func == dvc_pkg::FUNC_INTERNAL ||
                         req_func == dvc_pkg::FUNC_RECV_START);

   // no result survives reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result transaction valid right after reset");

   // a tick transaction stalls the input only for its tick step, then frees it
   a_tick_two_cycles: assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> req_stall ##1 !req_stall)
      else $error("tick transaction did not take two cycles");

   // a send never produces a result in the cycle right after its acceptance
   a_send_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_func == dvc_pkg::FUNC_SEND && !rsp_valid)
      |=> !rsp_valid)
      else $error("result appeared too early after a send");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_index) &&
                                    $stable(rsp_out_value) && $stable(rsp_last_pair)))
      else $error("stalled result transaction changed");

endmodule

bind differential_vector_clock_unit dvc_checker u_dvc_checker (.*);
